### rtl/core/qip_pkg.sv
// Shared types and constants for the four-lane incremental PI speed controller.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package qip_pkg;

    localparam int NUM_LANES  = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TARGET_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int LIMIT_W    = 8;
    localparam int DUTY_W     = 8;
    // Clamped accumulator lives in [-255, 255]
    localparam int ACC_W      = 9;
    // Increment saturated to [-512, 511]: enough to force any clamp
    localparam int INC_W      = 10;
    localparam int SUM4_W     = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_A = 3'd0,
        CFG_TARGET_B = 3'd1,
        CFG_TARGET_C = 3'd2,
        CFG_TARGET_D = 3'd3,
        CFG_PROP     = 3'd4,
        CFG_INTEG    = 3'd5,
        CFG_LIMIT    = 3'd6
    } t_cfg_idx;

    localparam logic [NUM_LANES-1:0][TARGET_W-1:0] TARGET_RST =
        {16'd20, 16'd50, 16'd50, 16'd50};
    localparam logic [GAIN_W-1:0]  PROP_RST  = 16'd25600;
    localparam logic [GAIN_W-1:0]  INTEG_RST = 16'd25600;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 8'd200;
    localparam logic [NUM_LANES-1:0][ACC_W-1:0] ACC_RST =
        {9'd150, 9'd0, 9'd0, 9'd0};

    typedef struct packed {
        logic [NUM_LANES-1:0][TARGET_W-1:0] target;
        logic [GAIN_W-1:0]                  prop;
        logic [GAIN_W-1:0]                  integ;
        logic [LIMIT_W-1:0]                 limit;
    } t_cfg;

    // Per-stage load strobes: stage k takes the item from stage k-1
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
    } t_stage_ld;

endpackage

`default_nettype wire

### rtl/core/qip_cfg_regs.sv
// Configuration register file: targets, gains and drive limit.
// Depends on qip_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qip_cfg_regs (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire [qip_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire [qip_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output qip_pkg::t_cfg                o_cfg
);

    qip_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target <= qip_pkg::TARGET_RST;
            r_cfg.prop   <= qip_pkg::PROP_RST;
            r_cfg.integ  <= qip_pkg::INTEG_RST;
            r_cfg.limit  <= qip_pkg::LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (qip_pkg::t_cfg_idx'(i_cfg_index))
                qip_pkg::CFG_TARGET_A: r_cfg.target[0] <= i_cfg_data;
                qip_pkg::CFG_TARGET_B: r_cfg.target[1] <= i_cfg_data;
                qip_pkg::CFG_TARGET_C: r_cfg.target[2] <= i_cfg_data;
                qip_pkg::CFG_TARGET_D: r_cfg.target[3] <= i_cfg_data;
                qip_pkg::CFG_PROP:     r_cfg.prop      <= i_cfg_data;
                qip_pkg::CFG_INTEG:    r_cfg.integ     <= i_cfg_data;
                qip_pkg::CFG_LIMIT:    r_cfg.limit     <= i_cfg_data[qip_pkg::LIMIT_W-1:0];
                default: begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/core/qip_pipe_ctrl.sv
// Valid tracking and stall control for the four-stage lane pipeline.
// Depends on qip_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qip_pipe_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output qip_pkg::t_stage_ld  o_ld
);

    logic r_v1, r_v2, r_v3, r_v4;
    logic w_en1, w_en2, w_en3, w_en4;

    // A stage may load when it is empty or its content moves on
    assign w_en4 = !r_v4 || i_out_ready;
    assign w_en3 = !r_v3 || w_en4;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;

    assign o_in_ready  = w_en1;
    assign o_out_valid = r_v4;

    assign o_ld.ld1 = w_en1 && i_in_valid;
    assign o_ld.ld2 = w_en2 && r_v1;
    assign o_ld.ld3 = w_en3 && r_v2;
    assign o_ld.ld4 = w_en4 && r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_in_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
        end
    end

endmodule

`default_nettype wire

### rtl/core/qip_lane.sv
// One controller lane: speed/error, gain products, scaled increment, clamp and duty.
// Depends on qip_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qip_lane #(
    parameter int COUNT_BITS     = 16,
    parameter int GAIN_FRAC_BITS = 8
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  qip_pkg::t_stage_ld               i_ld,
    input  wire [COUNT_BITS-1:0]             i_count,
    input  wire [qip_pkg::TARGET_W-1:0]      i_target,
    input  wire [qip_pkg::GAIN_W-1:0]        i_prop,
    input  wire [qip_pkg::GAIN_W-1:0]        i_integ,
    input  wire [qip_pkg::LIMIT_W-1:0]       i_limit,
    input  wire [qip_pkg::ACC_W-1:0]         i_acc_init,
    output logic [qip_pkg::DUTY_W-1:0]       o_fwd,
    output logic [qip_pkg::DUTY_W-1:0]       o_rev
);

    localparam int SPAN_W  = (COUNT_BITS > qip_pkg::TARGET_W) ? COUNT_BITS
                                                              : qip_pkg::TARGET_W;
    localparam int ERR_W   = SPAN_W + 1;
    localparam int DELTA_W = ERR_W + 1;
    localparam int PROD_W  = DELTA_W + qip_pkg::GAIN_W + 1;
    localparam int SUM_W   = PROD_W + 1;
    localparam logic signed [SUM_W-1:0] INC_MAX = SUM_W'((1 << (qip_pkg::INC_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] INC_MIN = -SUM_W'(1 << (qip_pkg::INC_W - 1));
    localparam logic signed [SUM_W-1:0] RND     = SUM_W'((1 << GAIN_FRAC_BITS) - 1);

    // stage 1: speed and error
    logic [COUNT_BITS-1:0]      r_prev;
    logic signed [ERR_W-1:0]    r_last_err;
    logic signed [COUNT_BITS-1:0] w_speed;
    logic signed [ERR_W-1:0]    w_err;
    logic signed [DELTA_W-1:0]  w_delta;
    logic signed [ERR_W-1:0]    r_err1;
    logic signed [DELTA_W-1:0]  r_delta1;

    assign w_speed = $signed(i_count - r_prev);
    assign w_err   = ERR_W'(w_speed) - ERR_W'($signed(i_target));
    assign w_delta = DELTA_W'(w_err) - DELTA_W'(r_last_err);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= '0;
            r_last_err <= '0;
        end else if (i_ld.ld1) begin
            r_prev     <= i_count;
            r_last_err <= w_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.ld1) begin
            r_err1   <= w_err;
            r_delta1 <= w_delta;
        end
    end

    // stage 2: gain products
    logic signed [qip_pkg::GAIN_W:0] w_prop_s, w_integ_s;
    logic signed [PROD_W-1:0]        r_pp, r_ip;

    assign w_prop_s  = $signed({1'b0, i_prop});
    assign w_integ_s = $signed({1'b0, i_integ});

    always_ff @(posedge i_clk) begin
        if (i_ld.ld2) begin
            r_pp <= PROD_W'(r_delta1) * PROD_W'(w_prop_s);
            r_ip <= PROD_W'(r_err1) * PROD_W'(w_integ_s);
        end
    end

    // stage 3: sum, divide toward zero, saturate the increment
    logic signed [SUM_W-1:0]           w_sum, w_quo;
    logic signed [qip_pkg::INC_W-1:0]  w_inc, r_inc;

    assign w_sum = SUM_W'(r_pp) + SUM_W'(r_ip);
    assign w_quo = (w_sum + (w_sum[SUM_W-1] ? RND : SUM_W'(0))) >>> GAIN_FRAC_BITS;

    always_comb begin
        priority if (w_quo > INC_MAX) begin
            w_inc = INC_MAX[qip_pkg::INC_W-1:0];
        end else if (w_quo < INC_MIN) begin
            w_inc = INC_MIN[qip_pkg::INC_W-1:0];
        end else begin
            w_inc = w_quo[qip_pkg::INC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.ld3) r_inc <= w_inc;
    end

    // stage 4: accumulate, clamp, split into duty pair
    logic signed [qip_pkg::ACC_W-1:0]  r_acc;
    logic signed [qip_pkg::SUM4_W-1:0] w_raw, w_lim, w_acc, w_neg;

    assign w_raw = qip_pkg::SUM4_W'(r_acc) + qip_pkg::SUM4_W'(r_inc);
    assign w_lim = $signed({{(qip_pkg::SUM4_W - qip_pkg::LIMIT_W){1'b0}}, i_limit});
    assign w_neg = -w_acc;

    always_comb begin
        priority if (w_raw > w_lim) begin
            w_acc = w_lim;
        end else if (w_raw < -w_lim) begin
            w_acc = -w_lim;
        end else begin
            w_acc = w_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= $signed(i_acc_init);
        end else if (i_ld.ld4) begin
            r_acc <= w_acc[qip_pkg::ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.ld4) begin
            if (w_acc[qip_pkg::SUM4_W-1]) begin
                o_fwd <= '0;
                o_rev <= w_neg[qip_pkg::DUTY_W-1:0];
            end else begin
                o_fwd <= w_acc[qip_pkg::DUTY_W-1:0];
                o_rev <= '0;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/quad_incremental_pi_speed_control.sv
// Top level of the four-channel incremental PI speed controller.
// Depends on qip_pkg, qip_cfg_regs, qip_pipe_ctrl and qip_lane.
//
//   channel   handshake                 payload
//   -------   -----------------------   ------------------------------------------
//   input     i_in_valid / o_in_ready   i_count_a .. i_count_d (one tick)
//   output    o_out_valid / i_out_ready o_fwd_duty_x, o_rev_duty_x for x = a..d
//   config    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Each tick passes through four lanes that run a four-stage pipeline (error, gain
// products, scaled increment, accumulate and clamp), and a new tick can be
// transferred every cycle while the output is not stalled. The per-lane
// count and error history advances in stage one and the drive accumulator in
// stage four, so back-to-back ticks see their predecessor's state.
// Reset is synchronous and active low; it restores the register defaults and
// lane state, and empties the pipeline. A stalled output holds its result while
// earlier stages keep filling any empty slots behind it.
`timescale 1ns / 1ps
`default_nettype none

module quad_incremental_pi_speed_control #(
    parameter int COUNT_BITS     = 16,
    parameter int GAIN_FRAC_BITS = 8
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    // tick input
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  wire [COUNT_BITS-1:0]          i_count_a,
    input  wire [COUNT_BITS-1:0]          i_count_b,
    input  wire [COUNT_BITS-1:0]          i_count_c,
    input  wire [COUNT_BITS-1:0]          i_count_d,
    // duty output
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output logic [qip_pkg::DUTY_W-1:0]    o_fwd_duty_a,
    output logic [qip_pkg::DUTY_W-1:0]    o_rev_duty_a,
    output logic [qip_pkg::DUTY_W-1:0]    o_fwd_duty_b,
    output logic [qip_pkg::DUTY_W-1:0]    o_rev_duty_b,
    output logic [qip_pkg::DUTY_W-1:0]    o_fwd_duty_c,
    output logic [qip_pkg::DUTY_W-1:0]    o_rev_duty_c,
    output logic [qip_pkg::DUTY_W-1:0]    o_fwd_duty_d,
    output logic [qip_pkg::DUTY_W-1:0]    o_rev_duty_d,
    // configuration writes
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire [qip_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [qip_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    qip_pkg::t_cfg      w_cfg;
    qip_pkg::t_stage_ld w_ld;

    logic [qip_pkg::NUM_LANES-1:0][COUNT_BITS-1:0]     w_count;
    logic [qip_pkg::NUM_LANES-1:0][qip_pkg::DUTY_W-1:0] w_fwd, w_rev;

    qip_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Shared stall/valid control: all lanes move in lockstep
    qip_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_ld        (w_ld)
    );

    assign w_count[0] = i_count_a;
    assign w_count[1] = i_count_b;
    assign w_count[2] = i_count_c;
    assign w_count[3] = i_count_d;

    // One lane per motor channel; each carries its own accumulator reset value
    for (genvar g = 0; g < qip_pkg::NUM_LANES; g++) begin : g_lane
        qip_lane #(
            .COUNT_BITS     (COUNT_BITS),
            .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
        ) u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ld       (w_ld),
            .i_count    (w_count[g]),
            .i_target   (w_cfg.target[g]),
            .i_prop     (w_cfg.prop),
            .i_integ    (w_cfg.integ),
            .i_limit    (w_cfg.limit),
            .i_acc_init (qip_pkg::ACC_RST[g]),
            .o_fwd      (w_fwd[g]),
            .o_rev      (w_rev[g])
        );
    end

    // Merge the lane results into the output transfer
    assign o_fwd_duty_a = w_fwd[0];
    assign o_rev_duty_a = w_rev[0];
    assign o_fwd_duty_b = w_fwd[1];
    assign o_rev_duty_b = w_rev[1];
    assign o_fwd_duty_c = w_fwd[2];
    assign o_rev_duty_c = w_rev[2];
    assign o_fwd_duty_d = w_fwd[3];
    assign o_rev_duty_d = w_rev[3];

endmodule

`default_nettype wire
